// File: rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants of the sliding window min/max unit.
// ----------------------------------------------------------------------------
package swmm_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int LEN_WIDTH    = 7;
   localparam int CNT_WIDTH    = $clog2(WINDOW_MAX + 1);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [LEN_WIDTH-1:0]           len_cfg_type;
   typedef logic [CNT_WIDTH-1:0]           count_type;

   typedef struct packed {
      sample_type sample;
      logic       start_of_sequence;
   } req_payload_type;

   typedef struct packed {
      sample_type window_min;
      sample_type window_max;
   } rsp_payload_type;

   // running extremes handed from cell to cell behind a one-cycle token
   typedef struct packed {
      logic       token;
      sample_type lo;
      sample_type hi;
   } link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

// File: rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One window cell: holds a sample, shifts it on, and folds it into the
// running min/max when the scan token passes through.
// ----------------------------------------------------------------------------
module swmm_cell
   import swmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  logic       active,
   input  sample_type sample_in,
   output sample_type sample_out,
   input  link_type   link_in,
   output link_type   link_out
);

   sample_type sample_ff;
   logic       token_ff;
   sample_type lo_ff, lo_in;
   sample_type hi_ff, hi_in;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (link_in.token) begin
         lo_in = link_in.lo;
         hi_in = link_in.hi;
         // cells beyond the window only pass the extremes along
         if (active && (sample_ff < link_in.lo)) begin
            lo_in = sample_ff;
         end
         if (active && (sample_ff > link_in.hi)) begin
            hi_in = sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= link_in.token;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign sample_out = sample_ff;
   assign link_out   = '{token: token_ff, lo: lo_ff, hi: hi_ff};

endmodule

// File: rtl/sliding_window_min_max_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_unit
// Running minimum and maximum over the newest window_length samples.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | direction
//  --------+------------------------------------+-----------
//  req     | req_valid, req_stall, req_payload  | in
//  rsp     | rsp_valid, rsp_stall, rsp_payload  | out
//  csr     | csr_write_enable, csr_write_data   | in
//
//  A word that yields no result leaves the unit idle; the next word is taken at once.
//  A word that yields a result starts a scan: the min/max token walks all
//  WINDOW_MAX cells of the chain, one cell per cycle, then loads the output.
//  req_stall stays high while the token walks and while a result waits for
//  a full output register. Synchronous reset clears the count, the tokens,
//  the output valid and sets window_length to 1; window samples are not reset.
//
module sliding_window_min_max_unit
   import swmm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  len_cfg_type     csr_write_data
);

   state_type       state_ff, state_in;
   count_type       len_ff, len_in;
   count_type       seen_ff, seen_in;
   logic            start_ff, start_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       req_take;
   logic       rsp_free;
   logic       want_result;
   count_type  seen_base;
   count_type  seen_next;
   link_type   head_link;
   link_type   tail_link;

   sample_type stored_sample [WINDOW_MAX];
   link_type   link_out      [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] token_vec;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // sample count of the current sequence, saturating at the store depth
   always_comb begin
      seen_base   = req_payload.start_of_sequence ? '0 : seen_ff;
      seen_next   = (seen_base < CNT_WIDTH'(WINDOW_MAX)) ? seen_base + 1'b1 : seen_base;
      want_result = (seen_next >= len_ff);
   end

   always_comb begin
      len_in = len_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            len_in = CNT_WIDTH'(1);
         end else if (32'(csr_write_data) > WINDOW_MAX) begin
            len_in = CNT_WIDTH'(WINDOW_MAX);
         end else begin
            len_in = CNT_WIDTH'(csr_write_data);
         end
      end
   end

   // ---- cell chain ---------------------------------------------------------
   assign head_link = '{token: start_ff, lo: stored_sample[0], hi: stored_sample[0]};
   assign tail_link = link_out[WINDOW_MAX-1];

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swmm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (req_take),
         .active     (32'(len_ff) > i),
         .sample_in  ((i == 0) ? req_payload.sample : stored_sample[(i == 0) ? 0 : i-1]),
         .sample_out (stored_sample[i]),
         .link_in    ((i == 0) ? head_link : link_out[(i == 0) ? 0 : i-1]),
         .link_out   (link_out[i])
      );
      assign token_vec[i] = link_out[i].token;
   end

   // ---- control ------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      seen_in        = seen_ff;
      start_in       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               seen_in = seen_next;
               if (want_result) begin
                  start_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (tail_link.token) begin
               if (rsp_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_payload_in = '{window_min: tail_link.lo, window_max: tail_link.hi};
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // tail cell holds its extremes until the output frees up
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{window_min: tail_link.lo, window_max: tail_link.hi};
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= CNT_WIDTH'(1);
         seen_ff      <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---- assertions ---------------------------------------------------------
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one scan token in the chain");

   a_token_in_scan : assert property (@(posedge clock) disable iff (reset)
      (token_vec != '0) |-> (state_ff == ST_SCAN))
      else $error("scan token outside of a scan");

   a_drain_needs_full_out : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> rsp_valid_ff)
      else $error("draining while output register is empty");

   a_start_follows_take : assert property (@(posedge clock) disable iff (reset)
      start_ff |-> ($past(req_valid) && (state_ff == ST_SCAN)))
      else $error("scan started without an accepted word");

   a_seen_bounded : assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_WIDTH'(WINDOW_MAX))
      else $error("sample count beyond window store depth");

endmodule

// File: verif/sliding_window_min_max_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_min_max_unit_test
// Self-checking bench for the sliding window min/max unit. A scoreboard keeps
// its own window of samples and a count per sequence, predicts the min/max
// of every full window and checks each response word against it. Phases
// with different window lengths run directed and random sequences, with
// random gaps on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module sliding_window_min_max_unit_test;
   import swmm_pkg::*;

   localparam int          WATCHDOG_LIMIT        = 5000;
   localparam int          SETTLE_CYCLES         = 80;
   localparam int          DRAIN_CYCLES          = 100;
   localparam int          MISMATCH_REPORT_LIMIT = 10;
   localparam int          RANDOM_WORDS          = 900;
   localparam int          HOLD_OFF_CYCLES       = 400;
   localparam int          HOLD_OFF_AFTER        = 40;
   localparam sample_type  SAMPLE_LOW            = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam sample_type  SAMPLE_HIGH           = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   class minmax_scoreboard;
      sample_type      history [WINDOW_MAX];
      int unsigned     seen;
      len_cfg_type     length_reg;
      rsp_payload_type expected_q [$];
      int unsigned     errors;
      int unsigned     results;

      function new();
         seen       = 0;
         length_reg = len_cfg_type'(1);
         errors     = 0;
         results    = 0;
      endfunction

      function void set_window_length(len_cfg_type len);
         length_reg = len;
      endfunction

      // zero acts as one, anything past the store depth saturates
      function int unsigned span();
         if (length_reg == 0) begin
            return 1;
         end
         if (length_reg > WINDOW_MAX) begin
            return WINDOW_MAX;
         end
         return length_reg;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_sample(req_payload_type w);
         sample_type      lo;
         sample_type      hi;
         int unsigned     n;
         rsp_payload_type want;
         if (w.start_of_sequence) begin
            seen = 0;
         end
         for (int i = WINDOW_MAX - 1; i > 0; i--) begin
            history[i] = history[i-1];
         end
         history[0] = w.sample;
         if (seen < WINDOW_MAX) begin
            seen++;
         end
         n = span();
         if (seen < n) begin
            return;
         end
         lo = history[0];
         hi = history[0];
         for (int i = 1; i < n; i++) begin
            if (history[i] < lo) begin
               lo = history[i];
            end
            if (history[i] > hi) begin
               hi = history[i];
            end
         end
         want.window_min = lo;
         want.window_max = hi;
         expected_q.push_back(want);
      endfunction

      function void flag(string what, sample_type want, sample_type got);
         errors++;
         if (errors <= MISMATCH_REPORT_LIMIT) begin
            $display("result %0d: %s expected %0d got %0d", results, what, want, got);
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         results++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MISMATCH_REPORT_LIMIT) begin
               $display("result %0d: unexpected word min %0d max %0d",
                        results, got.window_min, got.window_max);
            end
            return;
         end
         want = expected_q.pop_front();
         if (got.window_min !== want.window_min) begin
            flag("window_min", want.window_min, got.window_min);
         end
         if (got.window_max !== want.window_max) begin
            flag("window_max", want.window_max, got.window_max);
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable;
   len_cfg_type     csr_write_data;

   minmax_scoreboard sb;
   bit               hold_done;
   int unsigned      idle_cycles;

   sliding_window_min_max_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      hold_done        = 1'b0;
      idle_cycles      = 0;
      sb               = new;
   end

   always #1 clock = ~clock;

   // mostly short gaps, now and then a long one
   function int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end
      if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 40);
   endfunction

   function sample_type pick_sample();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0:       return SAMPLE_LOW;
            1:       return SAMPLE_HIGH;
            2:       return '0;
            default: return '1;
         endcase
      end
      if (r < 5) begin
         return sample_type'($signed($urandom_range(0, 16)) - 8);
      end
      return sample_type'($urandom());
   endfunction

   function len_cfg_type pick_length();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         return len_cfg_type'($urandom_range(1, 8));
      end
      if (r < 8) begin
         return len_cfg_type'($urandom_range(9, WINDOW_MAX));
      end
      if (r == 8) begin
         return len_cfg_type'($urandom_range(WINDOW_MAX + 1, 127));
      end
      return '0;
   endfunction

   // enter at a falling edge; leave at a falling edge after the word is taken
   task automatic offer_word(sample_type s, bit sos);
      int unsigned gap;
      req_payload.sample            = s;
      req_payload.start_of_sequence = sos;
      req_valid                     = 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_sample(req_payload);
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // write the length only once the unit has drained
   task automatic set_length(len_cfg_type len);
      req_valid = 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = len;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.set_window_length(len);
   endtask

   // response side: random stalls, long free runs, one long hold-off
   initial begin
      int unsigned r;
      @(negedge reset);
      forever begin
         if (!hold_done && sb.results >= HOLD_OFF_AFTER) begin
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_stall = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 15) begin
            repeat ($urandom_range(200, 400)) @(negedge clock);
         end else begin
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
         rsp_stall = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 80) begin
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else if (r < 95) begin
            repeat ($urandom_range(4, 15)) @(negedge clock);
         end else begin
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sliding_window_min_max_unit_test NOT OK");
         $finish;
      end
   end

   initial begin
      len_cfg_type fixed_lengths [6];
      len_cfg_type len;
      int unsigned total;
      int unsigned words;
      int unsigned phase;
      bit          fresh;
      bit          sos;
      fixed_lengths = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd65, 7'd2};
      total         = 0;
      phase         = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero length acts as one: every word gives a result
      set_length(7'd0);
      offer_word(SAMPLE_LOW, 1'b1);
      offer_word(SAMPLE_HIGH, 1'b0);
      offer_word('0, 1'b0);
      offer_word('1, 1'b0);
      // lengthen mid-sequence: count already covers it
      set_length(7'd3);
      offer_word(SAMPLE_HIGH, 1'b0);
      offer_word(SAMPLE_LOW, 1'b0);
      offer_word(sample_type'(1), 1'b0);
      // oversized length saturates: no result until the store is full
      set_length(7'd127);
      offer_word(sample_type'(5), 1'b0);
      offer_word(sample_type'(-5), 1'b0);
      // restarts in the middle of a window
      set_length(7'd2);
      offer_word(SAMPLE_HIGH, 1'b1);
      offer_word(SAMPLE_LOW, 1'b0);
      offer_word(sample_type'(3), 1'b1);
      offer_word(sample_type'(-3), 1'b1);
      offer_word(SAMPLE_LOW, 1'b0);
      offer_word(SAMPLE_HIGH, 1'b0);

      while (total < RANDOM_WORDS) begin
         len = (phase < 6) ? fixed_lengths[phase] : pick_length();
         set_length(len);
         words = $urandom_range(50, 100);
         fresh = ($urandom_range(0, 2) != 0);
         for (int k = 0; k < words; k++) begin
            sos = (k == 0 && fresh) || ($urandom_range(0, 2 * sb.span() + 8) == 0);
            offer_word(pick_sample(), sos);
         end
         total += words;
         phase++;
      end
      req_valid = 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("sliding_window_min_max_unit_test OK");
      end else begin
         $display("sliding_window_min_max_unit_test NOT OK");
      end
      $finish;
   end

endmodule
